// ----- design/ibpc_pkg.sv -----
// Package for the IR beacon period classifier.
// Holds shared types, register indexes and reset constants; no dependencies.
package ibpc_pkg;

  // Configuration port widths
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // Payload widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned NomW   = 24;
  localparam int unsigned TolW   = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned NumBeacons = 4;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_NOM_NE    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_NOM_NW    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_NOM_SW    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_NOM_SE    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_TOL_COM   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_TOL_SE    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 3'd6;

  // Register reset values
  localparam logic [NomW-1:0]   RST_NOM_NE    = 24'd23529;
  localparam logic [NomW-1:0]   RST_NOM_NW    = 24'd27586;
  localparam logic [NomW-1:0]   RST_NOM_SW    = 24'd20513;
  localparam logic [NomW-1:0]   RST_NOM_SE    = 24'd32000;
  localparam logic [TolW-1:0]   RST_TOL_COM   = 16'd300;
  localparam logic [TolW-1:0]   RST_TOL_SE    = 16'd400;
  localparam logic [CountW-1:0] RST_THRESHOLD = 8'd5;

  localparam logic [CountW-1:0] COUNT_MAX = 8'd255;

  // Beacon identifiers as reported on beacon_id
  typedef enum logic [1:0] {
    ID_NE = 2'd0,
    ID_NW = 2'd1,
    ID_SW = 2'd2,
    ID_SE = 2'd3
  } beacon_id_e;

  // Window hits for one period
  typedef struct packed {
    logic nw;
    logic ne;
    logic sw;
    logic se;
  } win_hits_t;

  // Confirmation report for one item
  typedef struct packed {
    logic       found;
    beacon_id_e id;
  } report_t;

endpackage

// ----- design/ibpc_window.sv -----
// One open tolerance window test: nominal - tol < period < nominal + tol.
// Depends on ibpc_pkg for widths.
module ibpc_window (
  input  logic [ibpc_pkg::TimeW-1:0] period_i,
  input  logic [ibpc_pkg::NomW-1:0]  nominal_i,
  input  logic [ibpc_pkg::TolW-1:0]  tol_i,
  output logic                       hit_o
);

  logic [ibpc_pkg::NomW:0] upper;
  logic [ibpc_pkg::NomW:0] lower;
  logic                    below_upper;
  logic                    above_lower;

  // Bounds in 25 bits; lower bit 24 set means the bound is negative
  always_comb begin
    upper = {1'b0, nominal_i} + {{(ibpc_pkg::NomW + 1 - ibpc_pkg::TolW){1'b0}}, tol_i};
    lower = {1'b0, nominal_i} - {{(ibpc_pkg::NomW + 1 - ibpc_pkg::TolW){1'b0}}, tol_i};
    below_upper = period_i < {{(ibpc_pkg::TimeW - ibpc_pkg::NomW - 1){1'b0}}, upper};
    above_lower = lower[ibpc_pkg::NomW] ||
                  (period_i > {{(ibpc_pkg::TimeW - ibpc_pkg::NomW){1'b0}},
                               lower[ibpc_pkg::NomW-1:0]});
    hit_o = below_upper && above_lower;
  end

endmodule

// ----- design/ibpc_confirm.sv -----
// Confirmation counters: saturating bump of the first matching window,
// report scan in NE, SE, NW, SW order, clear of the reported counter or of all on clear_i.
// Depends on ibpc_pkg.
module ibpc_confirm (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        clear_i,
  input  ibpc_pkg::win_hits_t         hits_i,
  input  logic [ibpc_pkg::CountW-1:0] threshold_i,
  output ibpc_pkg::report_t           report_o
);

  logic [ibpc_pkg::CountW-1:0] cnt_q [ibpc_pkg::NumBeacons];
  logic [ibpc_pkg::CountW-1:0] cnt_d [ibpc_pkg::NumBeacons];
  logic [ibpc_pkg::CountW-1:0] bumped [ibpc_pkg::NumBeacons];
  logic [ibpc_pkg::NumBeacons-1:0] sel;
  logic [ibpc_pkg::NumBeacons-1:0] over;

  // Priority pick of the window in NW, NE, SW, SE order
  always_comb begin
    sel = '0;
    priority if (hits_i.nw) sel[ibpc_pkg::ID_NW] = 1'b1;
    else if (hits_i.ne)     sel[ibpc_pkg::ID_NE] = 1'b1;
    else if (hits_i.sw)     sel[ibpc_pkg::ID_SW] = 1'b1;
    else if (hits_i.se)     sel[ibpc_pkg::ID_SE] = 1'b1;
    else                    sel = '0;
  end

  // Saturating increment and threshold compare per counter
  always_comb begin
    for (int i = 0; i < ibpc_pkg::NumBeacons; i++) begin
      if (sel[i] && (cnt_q[i] != ibpc_pkg::COUNT_MAX)) begin
        bumped[i] = cnt_q[i] + 1'b1;
      end else begin
        bumped[i] = cnt_q[i];
      end
      over[i] = bumped[i] > threshold_i;
    end
  end

  // Report scan in NE, SE, NW, SW order
  always_comb begin
    priority if (over[ibpc_pkg::ID_NE]) report_o = '{found: 1'b1, id: ibpc_pkg::ID_NE};
    else if (over[ibpc_pkg::ID_SE])     report_o = '{found: 1'b1, id: ibpc_pkg::ID_SE};
    else if (over[ibpc_pkg::ID_NW])     report_o = '{found: 1'b1, id: ibpc_pkg::ID_NW};
    else if (over[ibpc_pkg::ID_SW])     report_o = '{found: 1'b1, id: ibpc_pkg::ID_SW};
    else                                report_o = '{found: 1'b0, id: ibpc_pkg::ID_NE};
  end

  // Next counter values
  always_comb begin
    for (int i = 0; i < ibpc_pkg::NumBeacons; i++) begin
      if (clear_i) begin
        cnt_d[i] = '0;
      end else if (step_i) begin
        if (report_o.found && (report_o.id == ibpc_pkg::beacon_id_e'(i))) begin
          cnt_d[i] = '0;
        end else begin
          cnt_d[i] = bumped[i];
        end
      end else begin
        cnt_d[i] = cnt_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ibpc_pkg::NumBeacons; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < ibpc_pkg::NumBeacons; i++) begin
        cnt_q[i] <= cnt_d[i];
      end
    end
  end

endmodule

// ----- design/ir_beacon_period_classifier_top.sv -----
// Top level of the IR beacon period classifier: config registers, input and
// result registers, period subtract. Uses ibpc_pkg, ibpc_window, ibpc_confirm.
//
//   channel | handshake                | payload
//   --------+--------------------------+-------------------------------------------
//   in      | in_valid_i / in_stall_o  | mode_i, capture_time_i
//   out     | out_valid_o / out_stall_i| beacon_found_o, beacon_id_o, measured_period_o
//   cfg     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out_stall_i is low; each transferred input passes
// the input register, then subtract/compare/count into the result register.
// Reset loads the register defaults, clears counters and the previous capture.
// The input register keeps accepting while a result waits; in_stall_o rises only
// when both registers are full and out_stall_i is high. cfg_ready_o is always high.
module ir_beacon_period_classifier_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          mode_i,
  input  logic [ibpc_pkg::TimeW-1:0]    capture_time_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          beacon_found_o,
  output logic [1:0]                    beacon_id_o,
  output logic [ibpc_pkg::TimeW-1:0]    measured_period_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ibpc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ibpc_pkg::CfgDataW-1:0] cfg_data_i
);

  // Configuration registers
  logic [ibpc_pkg::NomW-1:0]   nom_ne_q, nom_nw_q, nom_sw_q, nom_se_q;
  logic [ibpc_pkg::TolW-1:0]   tol_com_q, tol_se_q;
  logic [ibpc_pkg::CountW-1:0] thr_q;

  // Pipeline registers
  logic                        in_vld_q, in_vld_d;
  logic                        in_mode_q;
  logic [ibpc_pkg::TimeW-1:0]  in_time_q;
  logic                        out_vld_q, out_vld_d;
  logic                        out_found_q;
  logic [1:0]                  out_id_q;
  logic [ibpc_pkg::TimeW-1:0]  out_period_q;
  logic [ibpc_pkg::TimeW-1:0]  prev_q;

  logic                        advance;
  logic                        in_load;
  logic                        step;
  logic                        clear;
  logic [ibpc_pkg::TimeW-1:0]  period;
  ibpc_pkg::win_hits_t         hits;
  ibpc_pkg::report_t           report;

  assign cfg_ready_o = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nom_ne_q  <= ibpc_pkg::RST_NOM_NE;
      nom_nw_q  <= ibpc_pkg::RST_NOM_NW;
      nom_sw_q  <= ibpc_pkg::RST_NOM_SW;
      nom_se_q  <= ibpc_pkg::RST_NOM_SE;
      tol_com_q <= ibpc_pkg::RST_TOL_COM;
      tol_se_q  <= ibpc_pkg::RST_TOL_SE;
      thr_q     <= ibpc_pkg::RST_THRESHOLD;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ibpc_pkg::REG_NOM_NE:    nom_ne_q  <= cfg_data_i;
        ibpc_pkg::REG_NOM_NW:    nom_nw_q  <= cfg_data_i;
        ibpc_pkg::REG_NOM_SW:    nom_sw_q  <= cfg_data_i;
        ibpc_pkg::REG_NOM_SE:    nom_se_q  <= cfg_data_i;
        ibpc_pkg::REG_TOL_COM:   tol_com_q <= cfg_data_i[ibpc_pkg::TolW-1:0];
        ibpc_pkg::REG_TOL_SE:    tol_se_q  <= cfg_data_i[ibpc_pkg::TolW-1:0];
        ibpc_pkg::REG_THRESHOLD: thr_q     <= cfg_data_i[ibpc_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the item in the input register moves on whenever the result
  // register is empty or its result is being taken
  always_comb begin
    advance    = in_vld_q && (!out_vld_q || !out_stall_i);
    in_stall_o = in_vld_q && out_vld_q && out_stall_i;
    in_load    = in_valid_i && !in_stall_o;
    step       = advance && !in_mode_q;
    clear      = advance && in_mode_q;

    if (in_load) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end else begin
      in_vld_d = in_vld_q;
    end

    if (advance) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      prev_q    <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (step) begin
        prev_q <= in_time_q;
      end
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      in_mode_q <= mode_i;
      in_time_q <= capture_time_i;
    end
  end

  // Period since previous edge, wraps modulo 2^32
  assign period = in_time_q - prev_q;

  ibpc_window u_win_nw (
    .period_i (period),
    .nominal_i(nom_nw_q),
    .tol_i    (tol_com_q),
    .hit_o    (hits.nw)
  );

  ibpc_window u_win_ne (
    .period_i (period),
    .nominal_i(nom_ne_q),
    .tol_i    (tol_com_q),
    .hit_o    (hits.ne)
  );

  ibpc_window u_win_sw (
    .period_i (period),
    .nominal_i(nom_sw_q),
    .tol_i    (tol_com_q),
    .hit_o    (hits.sw)
  );

  ibpc_window u_win_se (
    .period_i (period),
    .nominal_i(nom_se_q),
    .tol_i    (tol_se_q),
    .hit_o    (hits.se)
  );

  ibpc_confirm u_confirm (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .clear_i    (clear),
    .hits_i     (hits),
    .threshold_i(thr_q),
    .report_o   (report)
  );

  // Result register; a clear item reports all zeros
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (in_mode_q) begin
        out_found_q  <= 1'b0;
        out_id_q     <= ibpc_pkg::ID_NE;
        out_period_q <= '0;
      end else begin
        out_found_q  <= report.found;
        out_id_q     <= report.id;
        out_period_q <= period;
      end
    end
  end

  assign out_valid_o       = out_vld_q;
  assign beacon_found_o    = out_found_q;
  assign beacon_id_o       = out_id_q;
  assign measured_period_o = out_period_q;

endmodule

// ----- design/ibpc_checker.sv -----
// Port-level checker for the IR beacon period classifier, bound to the top.
// Depends on ibpc_pkg for widths.
module ibpc_port_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       beacon_found_o,
  input logic [1:0]                 beacon_id_o,
  input logic [ibpc_pkg::TimeW-1:0] measured_period_o
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(measured_period_o) &&
      $stable(beacon_found_o) && $stable(beacon_id_o))
    else $error("result changed while stalled");

  // No beacon reported means id zero
  a_id_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !beacon_found_o |-> beacon_id_o == 2'd0)
    else $error("beacon_id set without beacon_found");

  // Input side only stalls when a result is held back
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while output side is free");

endmodule

bind ir_beacon_period_classifier_top ibpc_port_checker u_ibpc_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .beacon_found_o   (beacon_found_o),
  .beacon_id_o      (beacon_id_o),
  .measured_period_o(measured_period_o)
);
